// ===== src/prlu_pkg.sv =====
package prlu_pkg;

   localparam int RANK_W  = 13;
   localparam int QUERY_W = 32;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clr_step;
      logic sieve_init;
      logic rd_prime;
      logic p_next;
      logic mark_init;
      logic mark_step;
      logic scan_init;
      logic scan_step;
      logic q_load;
      logic rd_query;
      logic search_init;
      logic probe_rd;
      logic probe_upd;
      logic rsp_send;
      logic rsp_hit;
   } ctl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clr_last;
      logic sieve_done;
      logic flag_bit;
      logic mark_last;
      logic scan_last;
      logic q_in_range;
      logic search_empty;
      logic probe_eq;
   } dp_status_type;

endpackage

// ===== src/prime_rank_lookup_unit.sv =====
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+---------------------------
// request   | start, busy, req_query_number[31:0]     | taken when start && !busy
// response  | rsp_valid, rsp_is_listed_prime,         | one-cycle strobe, no stall
//           | rsp_prime_rank[12:0]                    |
//
// after reset busy stays high while the table is built: flag clearing over
// entries 0..SIEVE_LIMIT, a flag read per sieving prime candidate and, for a prime,
// marking of its multiples from its square, then a list scan of 2..SIEVE_LIMIT.
// a query passes the range check, the flag read and k binary search probes
// (k <= 13 at the default limit); each probe reads the list memory in ST_Q_PROBE
// and compares in ST_Q_CMP; out of range, zero, one and composites need no probe.
// the receiver cannot stall; a response strobe may overlap the next accept.
module prime_rank_lookup_unit
   import prlu_pkg::*;
#(
   parameter int SIEVE_LIMIT = 65536
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [QUERY_W-1:0] req_query_number,
   output logic               rsp_valid,
   output logic               rsp_is_listed_prime,
   output logic [RANK_W-1:0]  rsp_prime_rank
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   prlu_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   prlu_datapath #(
      .SIEVE_LIMIT (SIEVE_LIMIT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_query_number    (req_query_number),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_is_listed_prime (rsp_is_listed_prime),
      .rsp_prime_rank      (rsp_prime_rank)
   );

endmodule

// ===== src/prlu_ctrl.sv =====
module prlu_ctrl
   import prlu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctl_cmd_type   cmd,
   output logic          busy
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_SIEVE_RD,
      ST_SIEVE_CHK,
      ST_MARK,
      ST_LIST,
      ST_LIST_DRAIN,
      ST_IDLE,
      ST_Q_RANGE,
      ST_Q_FLAG,
      ST_Q_PROBE,
      ST_Q_CMP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               cmd.sieve_init = 1'b1;
               state_in       = ST_SIEVE_RD;
            end
         end
         ST_SIEVE_RD: begin
            if (status.sieve_done) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_LIST;
            end else begin
               cmd.rd_prime = 1'b1;
               state_in     = ST_SIEVE_CHK;
            end
         end
         ST_SIEVE_CHK: begin
            if (status.flag_bit) begin
               cmd.mark_init = 1'b1;
               state_in      = ST_MARK;
            end else begin
               cmd.p_next = 1'b1;
               state_in   = ST_SIEVE_RD;
            end
         end
         ST_MARK: begin
            cmd.mark_step = 1'b1;
            if (status.mark_last) begin
               cmd.p_next = 1'b1;
               state_in   = ST_SIEVE_RD;
            end
         end
         ST_LIST: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_LIST_DRAIN;
            end
         end
         ST_LIST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.q_load = 1'b1;
               state_in   = ST_Q_RANGE;
            end
         end
         ST_Q_RANGE: begin
            if (status.q_in_range) begin
               cmd.rd_query = 1'b1;
               state_in     = ST_Q_FLAG;
            end else begin
               cmd.rsp_send = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_Q_FLAG: begin
            if (status.flag_bit) begin
               cmd.search_init = 1'b1;
               state_in        = ST_Q_PROBE;
            end else begin
               cmd.rsp_send = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_Q_PROBE: begin
            if (status.search_empty) begin
               cmd.rsp_send = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.probe_rd = 1'b1;
               state_in     = ST_Q_CMP;
            end
         end
         ST_Q_CMP: begin
            if (status.probe_eq) begin
               cmd.rsp_send = 1'b1;
               cmd.rsp_hit  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.probe_upd = 1'b1;
               state_in      = ST_Q_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// ===== src/prlu_datapath.sv =====
module prlu_datapath
   import prlu_pkg::*;
#(
   parameter int SIEVE_LIMIT = 65536
)
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   input  logic [QUERY_W-1:0]  req_query_number,
   output dp_status_type       status,
   output logic                rsp_valid,
   output logic                rsp_is_listed_prime,
   output logic [RANK_W-1:0]   rsp_prime_rank
);

   localparam int FW         = $clog2(SIEVE_LIMIT + 1);
   localparam int SW         = FW + 1;
   // every prime above 3 is 1 or 5 mod 6, so this bounds the prime count
   localparam int LIST_DEPTH = SIEVE_LIMIT / 3 + 2;
   localparam int LW         = $clog2(LIST_DEPTH);
   localparam int CW         = $clog2(LIST_DEPTH + 1);

   localparam logic [FW-1:0]      LIMIT_F = FW'(SIEVE_LIMIT);
   localparam logic [SW-1:0]      LIMIT_S = SW'(SIEVE_LIMIT);
   localparam logic [QUERY_W-1:0] LIMIT_Q = QUERY_W'(SIEVE_LIMIT);
   localparam logic [CW-1:0]      DEPTH_C = CW'(LIST_DEPTH);

   logic flag_mem [0:SIEVE_LIMIT];
   logic [FW-1:0] list_mem [0:LIST_DEPTH-1];

   logic [FW-1:0]      n_ff;
   logic [FW-1:0]      n_d_ff;
   logic               scan_vld_ff;
   logic [FW-1:0]      p_ff;
   logic [SW-1:0]      sq_ff;
   logic [SW-1:0]      m_ff;
   logic [CW-1:0]      count_ff;
   logic [QUERY_W-1:0] q_ff;
   logic [CW-1:0]      lo_ff;
   logic [CW-1:0]      hi_ff;
   logic [LW-1:0]      mid_ff;
   logic               flag_rd_ff;
   logic [FW-1:0]      list_rd_ff;
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [RANK_W-1:0]  rsp_rank_ff;

   logic [FW-1:0] flag_ra;
   logic [FW-1:0] flag_wa;
   logic          flag_we;
   logic          flag_wd;
   logic [CW-1:0] mid_calc;
   logic [SW-1:0] m_plus_p;
   logic          list_we;

   always_comb begin
      flag_ra = n_ff;
      if (cmd.rd_prime) begin
         flag_ra = p_ff;
      end else if (cmd.rd_query) begin
         flag_ra = q_ff[FW-1:0];
      end
   end

   always_comb begin
      flag_we = 1'b0;
      flag_wa = n_ff;
      flag_wd = 1'b0;
      if (cmd.clr_step) begin
         flag_we = 1'b1;
         flag_wa = n_ff;
         flag_wd = (n_ff >= FW'(2));
      end else if (cmd.mark_step) begin
         flag_we = 1'b1;
         flag_wa = m_ff[FW-1:0];
         flag_wd = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      flag_rd_ff <= flag_mem[flag_ra];
   end

   assign list_we  = scan_vld_ff && flag_rd_ff && (count_ff < DEPTH_C);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign m_plus_p = m_ff + SW'(p_ff);

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[count_ff[LW-1:0]] <= n_d_ff;
      end
      if (cmd.probe_rd) begin
         list_rd_ff <= list_mem[mid_calc[LW-1:0]];
      end
   end

   // sieve counters, query, search and response registers
   always_ff @(posedge clock) begin
      if (cmd.sieve_init) begin
         p_ff  <= FW'(2);
         sq_ff <= SW'(4);
      end else if (cmd.p_next) begin
         p_ff  <= p_ff + FW'(1);
         sq_ff <= sq_ff + {p_ff, 1'b0} + SW'(1);
      end
      if (cmd.mark_init) begin
         m_ff <= sq_ff;
      end else if (cmd.mark_step) begin
         m_ff <= m_plus_p;
      end
      if (cmd.scan_step) begin
         n_d_ff <= n_ff;
      end
      if (cmd.q_load) begin
         q_ff <= req_query_number;
      end
      if (cmd.search_init) begin
         lo_ff <= '0;
         hi_ff <= count_ff;
      end else if (cmd.probe_upd) begin
         if (q_ff[FW-1:0] > list_rd_ff) begin
            lo_ff <= CW'(mid_ff) + CW'(1);
         end else begin
            hi_ff <= CW'(mid_ff);
         end
      end
      if (cmd.probe_rd) begin
         mid_ff <= mid_calc[LW-1:0];
      end
      if (cmd.rsp_send) begin
         rsp_hit_ff  <= cmd.rsp_hit;
         rsp_rank_ff <= cmd.rsp_hit ? RANK_W'(mid_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         scan_vld_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.scan_init) begin
            n_ff <= FW'(2);
         end else if (cmd.clr_step || cmd.scan_step) begin
            n_ff <= n_ff + FW'(1);
         end
         scan_vld_ff <= cmd.scan_step;
         if (cmd.scan_init) begin
            count_ff <= '0;
         end else if (list_we) begin
            count_ff <= count_ff + CW'(1);
         end
         rsp_valid_ff <= cmd.rsp_send;
      end
   end

   always_comb begin
      status.clr_last     = (n_ff == LIMIT_F);
      status.sieve_done   = (sq_ff > LIMIT_S);
      status.flag_bit     = flag_rd_ff;
      status.mark_last    = (m_plus_p > LIMIT_S);
      status.scan_last    = (n_ff == LIMIT_F);
      status.q_in_range   = (q_ff < LIMIT_Q);
      status.search_empty = (lo_ff >= hi_ff);
      status.probe_eq     = (q_ff[FW-1:0] == list_rd_ff);
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_listed_prime = rsp_hit_ff;
   assign rsp_prime_rank      = rsp_rank_ff;

endmodule

// ===== src/prlu_checker.sv =====
module prlu_checker
   import prlu_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [QUERY_W-1:0] req_query_number,
   input logic               rsp_valid,
   input logic               rsp_is_listed_prime,
   input logic [RANK_W-1:0]  rsp_prime_rank
);

   // a non-prime answer always carries rank zero
   a_rank_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_listed_prime |-> rsp_prime_rank == '0)
      else $error("nonzero rank on a miss");

   // an accepted transaction makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("not busy after accept");

   // exactly one response per transaction, so no back-to-back strobes
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held two cycles");

   // a response comes out as the block goes idle
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("response outside end of transaction");

   // a listed prime is always below SIEVE_LIMIT, so below 2^20 when SIEVE_LIMIT <= 2^20
   a_hit_small_query: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_query_number[31:20] != '0) |=> ##1 !rsp_is_listed_prime)
      else $error("prime reported for an out-of-range number");

endmodule

bind prime_rank_lookup_unit prlu_checker u_prlu_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_query_number    (req_query_number),
   .rsp_valid           (rsp_valid),
   .rsp_is_listed_prime (rsp_is_listed_prime),
   .rsp_prime_rank      (rsp_prime_rank)
);
